// ===== hw/rtl/lru_key_value_cache_defines.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Check a property on i_clk, masked while reset is held.
`define KVC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on i_clk, reset included.
`define KVC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/lru_kvc_pkg.sv =====
// Shared constants, types and helpers of the LRU key-value cache.
package lru_kvc_pkg;

    localparam int unsigned MAX_ENTRIES = 16;
    localparam int unsigned IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned CAP_W       = 5;

    localparam logic [CAP_W-1:0]         CAP_RESET  = CAP_W'(16);
    localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

    // Operation carried in the mode field of an input word.
    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_entry;

    // Clamp the capacity register to the usable range 1..MAX_ENTRIES.
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] c;
        if (32'(cap) > MAX_ENTRIES) begin
            c = CNT_W'(MAX_ENTRIES);
        end else if (cap == '0) begin
            c = CNT_W'(1);
        end else begin
            c = CNT_W'(cap);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/lru_kvc_ifs.sv =====
// Handshake channel interfaces of the LRU key-value cache.
interface lru_kvc_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      mode;
    logic signed [lru_kvc_pkg::DATA_W-1:0]     key;
    logic signed [lru_kvc_pkg::DATA_W-1:0]     value;

    modport source (output valid, output mode, output key, output value, input ready);
    modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface lru_kvc_out_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      hit;
    logic signed [lru_kvc_pkg::DATA_W-1:0]     read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lru_kvc_cfg_if;
    logic                                      valid;
    logic                                      ready;
    logic [lru_kvc_pkg::CAP_W-1:0]             capacity_in_use;

    modport source (output valid, output capacity_in_use, input ready);
    modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== hw/rtl/lru_key_value_cache.sv =====
// Top level of the fully associative key-value cache with LRU replacement.
// A get word is scanned entry by entry (up to 16 entries), then in the finish state it
// is loaded into the output register once that register is free or being drained.
// A new word is accepted only in the idle state, after the previous one has finished.
// Reset (i_rst_n low, synchronous) clears valid bits, ranks and fill count at once;
// no clearing pass runs, and the capacity returns to 16.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lru_kvc_in_if.sink    i_in,
    lru_kvc_out_if.source o_out,
    lru_kvc_cfg_if.sink   i_cfg
);

    localparam int unsigned N  = lru_kvc_pkg::MAX_ENTRIES;
    localparam int unsigned IW = lru_kvc_pkg::IDX_W;
    localparam int unsigned CW = lru_kvc_pkg::CNT_W;
    localparam int unsigned DW = lru_kvc_pkg::DATA_W;

    // Control state
    lru_kvc_pkg::t_state           r_state, n_state;
    logic [lru_kvc_pkg::CAP_W-1:0] r_cap;
    logic [N-1:0]                  r_valid;
    logic [IW-1:0]                 r_rank [N];  // 0 = most recent
    logic [CW-1:0]                 r_used;

    // Word under work
    logic                          r_mode;
    logic [DW-1:0]                 r_key;
    logic [DW-1:0]                 r_value;
    logic [IW-1:0]                 r_idx;
    logic                          r_hit;
    logic [IW-1:0]                 r_slot;
    logic [IW-1:0]                 r_hit_rank;
    logic [DW-1:0]                 r_hit_value;

    // Output register
    logic                          r_out_valid;
    logic                          r_out_hit;
    logic [DW-1:0]                 r_out_value;

    // Key/value memory, registered read
    lru_kvc_pkg::t_entry           r_mem [N];
    lru_kvc_pkg::t_entry           r_rd_data;

    logic                          w_accept;
    logic                          w_in_ready;
    logic                          w_is_put;
    logic [IW-1:0]                 w_rd_addr;
    logic                          w_match;
    logic                          w_last;
    logic                          w_fin;
    logic                          w_wr_en;
    logic [IW-1:0]                 w_wr_addr;

    logic [CW-1:0]                 w_cap;
    logic [CW-1:0]                 w_cap_m1;
    logic                          w_need_evict;
    logic [N-1:0]                  w_kept;
    logic [IW-1:0]                 w_free_slot;
    logic [N-1:0]                  w_valid_ins;
    logic [CW-1:0]                 w_used_after;

    assign w_accept    = i_in.valid && w_in_ready;
    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_out_hit;
    assign o_out.read_value = r_out_value;

    assign w_is_put = (r_mode == lru_kvc_pkg::OP_PUT);
    assign w_match  = r_valid[r_idx] && (r_rd_data.key == r_key);
    assign w_last   = (r_idx == IW'(N - 1));

    // Next state, read address and the finish strobe.
    // A get only finishes once the output register is free or being drained.
    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_rd_addr  = '0;
        w_fin      = 1'b0;
        case (r_state)
            lru_kvc_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = lru_kvc_pkg::S_SCAN;
                end
            end
            lru_kvc_pkg::S_SCAN: begin
                w_rd_addr = IW'(r_idx + 1'b1);
                if (w_match || w_last) begin
                    n_state = lru_kvc_pkg::S_FINISH;
                end
            end
            lru_kvc_pkg::S_FINISH: begin
                if (w_is_put || !r_out_valid || o_out.ready) begin
                    w_fin   = 1'b1;
                    n_state = lru_kvc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lru_kvc_pkg::S_IDLE;
            end
        endcase
    end

    // Eviction and free-slot search for a put of an absent key. Ranks of the
    // valid entries are a permutation of 0..used-1, so dropping every entry
    // ranked at or above capacity-1 equals evicting the oldest repeatedly.
    always_comb begin
        w_cap        = lru_kvc_pkg::eff_cap(r_cap);
        w_cap_m1     = CW'(w_cap - 1'b1);
        w_need_evict = (r_used >= w_cap);
        w_used_after = w_need_evict ? w_cap_m1 : r_used;
        for (int i = 0; i < N; i++) begin
            w_kept[i] = r_valid[i] && !(w_need_evict && (CW'(r_rank[i]) >= w_cap_m1));
        end
        w_free_slot = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (!w_kept[i]) begin
                w_free_slot = IW'(i);
            end
        end
        w_valid_ins              = w_kept;
        w_valid_ins[w_free_slot] = 1'b1;
    end

    // Any put writes the key/value pair: in place on a hit, else into the free slot.
    assign w_wr_en   = w_fin && w_is_put;
    assign w_wr_addr = r_hit ? r_slot : w_free_slot;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= '{key: r_key, value: r_value};
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lru_kvc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Entry bookkeeping and capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= lru_kvc_pkg::CAP_RESET;
            r_valid <= '0;
            r_used  <= '0;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                r_cap <= i_cfg.capacity_in_use;
            end
            if (w_fin) begin
                if (r_hit) begin
                    // Touch: age the entries more recent than the hit, promote the hit.
                    for (int i = 0; i < N; i++) begin
                        if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                            r_rank[i] <= IW'(r_rank[i] + 1'b1);
                        end
                    end
                    r_rank[r_slot] <= '0;
                end else if (w_is_put) begin
                    // Insert: age every survivor, place the new entry as most recent.
                    for (int i = 0; i < N; i++) begin
                        if (w_kept[i]) begin
                            r_rank[i] <= IW'(r_rank[i] + 1'b1);
                        end
                    end
                    r_rank[w_free_slot] <= '0;
                    r_valid             <= w_valid_ins;
                    r_used              <= CW'(w_used_after + 1'b1);
                end
            end
        end
    end

    // Scan bookkeeping: latch the word, step the index, capture a hit.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= i_in.mode;
            r_key   <= i_in.key;
            r_value <= i_in.value;
            r_idx   <= '0;
            r_hit   <= 1'b0;
        end else if (r_state == lru_kvc_pkg::S_SCAN) begin
            if (w_match) begin
                r_hit       <= 1'b1;
                r_slot      <= r_idx;
                r_hit_rank  <= r_rank[r_idx];
                r_hit_value <= r_rd_data.value;
            end else if (!w_last) begin
                r_idx <= IW'(r_idx + 1'b1);
            end
        end
    end

    // Output register: load on a finished get, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin && !w_is_put) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_fin && !w_is_put) begin
            r_out_hit   <= r_hit;
            r_out_value <= r_hit ? r_hit_value : lru_kvc_pkg::MISS_VALUE;
        end
    end

    `KVC_ASSERT(a_used_matches_valid, r_used == CW'($countones(r_valid)), "fill count differs from valid bits")
    `KVC_ASSERT(a_insert_within_cap, (w_fin && w_is_put && !r_hit) |=> (r_used <= $past(w_cap)), "insert overfills the cache")
    `KVC_ASSERT(a_out_from_get, $rose(r_out_valid) |-> $past(w_fin && !w_is_put), "result word not caused by a get")
    `KVC_ASSERT(a_hit_slot_valid, (r_state == lru_kvc_pkg::S_FINISH && r_hit) |-> r_valid[r_slot], "hit on an invalid slot")
    `KVC_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_state == lru_kvc_pkg::S_IDLE && !r_out_valid), "reset left the cache busy")

endmodule
